[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands; clock clk, reset arst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VURI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VURI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/vuri_pkg.sv]
// ---------------------------------------------------------------------------
// vuri_pkg
// Types and constants of the video unit register interface.
// ---------------------------------------------------------------------------
package vuri_pkg;

	// command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// register indexes
	localparam logic [2:0] REG_CTRL    = 3'd0;
	localparam logic [2:0] REG_MASK    = 3'd1;
	localparam logic [2:0] REG_STATUS  = 3'd2;
	localparam logic [2:0] REG_SPR_ADR = 3'd3;
	localparam logic [2:0] REG_SPR_DAT = 3'd4;
	localparam logic [2:0] REG_SCROLL  = 3'd5;
	localparam logic [2:0] REG_VID_ADR = 3'd6;
	localparam logic [2:0] REG_VID_DAT = 3'd7;

	// nametable mirroring codes (anything else is four-screen)
	localparam logic [1:0] MIR_HORIZ = 2'd0;
	localparam logic [1:0] MIR_VERT  = 2'd1;

	// raster timing
	localparam logic [8:0] DOTS_PER_LINE   = 9'd341;
	localparam logic [8:0] LINES_PER_FRAME = 9'd262;
	localparam logic [8:0] VBLANK_LINE     = 9'd241;
	localparam logic [8:0] PRERENDER_LINE  = 9'd261;
	localparam logic [8:0] FLAG_DOT        = 9'd1;

	// store depths
	localparam int unsigned PATTERN_DEPTH = 8192;
	localparam int unsigned NAME_DEPTH    = 4096;  // 2 KB main + 2 KB four-screen extra
	localparam int unsigned PAL_DEPTH     = 32;
	localparam int unsigned SPRITE_DEPTH  = 256;

	// palette page of the video space, upper address bits 13:8
	localparam logic [5:0] PAL_PAGE = 6'h3F;

	// video store select
	localparam logic [1:0] VSEL_NONE    = 2'd0;
	localparam logic [1:0] VSEL_PATTERN = 2'd1;
	localparam logic [1:0] VSEL_NAME    = 2'd2;
	localparam logic [1:0] VSEL_PALETTE = 2'd3;

	// read data source of a response
	localparam logic [1:0] RD_ZERO   = 2'd0;
	localparam logic [1:0] RD_STATUS = 2'd1;
	localparam logic [1:0] RD_SPRITE = 2'd2;
	localparam logic [1:0] RD_VIDEO  = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [13:0] cpu_addr;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       nmi_raise;
		logic       vblank_now;
	} rsp_t;

endpackage

[src/video_unit_register_interface.sv]
// ---------------------------------------------------------------------------
// video_unit_register_interface
// Dot/line timing and the eight CPU registers of a tile video unit.
// ---------------------------------------------------------------------------
// Each request is a dot tick, a CPU register read or a CPU register write
// (register index = cpu_addr[2:0]); each request yields exactly one response.
// Requests are taken at up to one per clock while req_ready is high. The RAM
// read is registered at the request transfer edge into stage 1; the response
// register loads from stage 1 when stage 1 advances, which waits while an
// earlier response is held unaccepted. A request is still taken while one
// response waits. All state that lives in RAM (pattern 8 KB, nametable 2 KB +
// 2 KB four-screen extra, 32-byte palette, 256-byte sprite memory) is one access
// per request through a single port, so each store sees at most one access a
// cycle. After reset a clearing pass writes zero through every address of
// all stores in parallel; req_ready stays low during it, while mirroring
// writes on cfg_wr_en are taken at any time. The buffered data read uses the
// byte fetched by the previous data read, forwarded from the RAM output in
// request order; palette reads return the fresh byte. Mask and scroll writes
// are accepted and have no visible effect at this interface.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module video_unit_register_interface (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  vuri_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output vuri_pkg::rsp_t rsp,
	input  logic          cfg_wr_en,
	input  logic [1:0]    cfg_wr_data
);

	localparam int unsigned PAT_AW  = $clog2(vuri_pkg::PATTERN_DEPTH);
	localparam int unsigned NAME_AW = $clog2(vuri_pkg::NAME_DEPTH);
	localparam int unsigned PAL_AW  = $clog2(vuri_pkg::PAL_DEPTH);
	localparam int unsigned SPR_AW  = $clog2(vuri_pkg::SPRITE_DEPTH);

	// ---------------- clearing pass ----------------
	logic              clear_q;
	logic [PAT_AW-1:0] clear_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q     <= 1'b1;
			clear_cnt_q <= '0;
		end else if (clear_q) begin
			clear_cnt_q <= clear_cnt_q + 1'b1;
			if (clear_cnt_q == PAT_AW'(vuri_pkg::PATTERN_DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// ---------------- architectural registers ----------------
	logic [1:0]  mirror_q;
	logic [8:0]  dot_q;
	logic [8:0]  line_q;
	logic        vblank_q;       // status bit 7; other status bits read zero
	logic        ctrl_nmi_q;     // control bit 7
	logic        ctrl_inc32_q;   // control bit 2
	logic [7:0]  spr_ptr_q;
	logic        addr_toggle_q;
	logic [15:0] vptr_q;
	logic [7:0]  rbuf_q;         // delayed read byte

	// ---------------- handshake ----------------
	logic valid_s1;
	logic rsp_valid_q;
	logic s1_advance;
	logic accept;

	assign s1_advance = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready  = !clear_q && (!valid_s1 || s1_advance);
	assign accept     = req_valid && req_ready;

	logic [2:0] reg_idx;
	logic       is_tick;
	logic       is_read;
	logic       is_write;

	assign reg_idx  = req.cpu_addr[2:0];
	assign is_tick  = (req.cmd == vuri_pkg::CMD_TICK);
	assign is_read  = (req.cmd == vuri_pkg::CMD_READ);
	assign is_write = (req.cmd == vuri_pkg::CMD_WRITE);

	// ---------------- video address decode ----------------
	logic [1:0]         vsel;
	logic [NAME_AW-1:0] name_addr;
	logic [PAL_AW-1:0]  pal_addr;

	always_comb begin
		if (vptr_q[15:14] != 2'b00) begin
			vsel = vuri_pkg::VSEL_NONE;      // pointer above 14 bits: unmapped
		end else if (!vptr_q[13]) begin
			vsel = vuri_pkg::VSEL_PATTERN;
		end else if (vptr_q[13:8] != vuri_pkg::PAL_PAGE) begin
			vsel = vuri_pkg::VSEL_NAME;
		end else begin
			vsel = vuri_pkg::VSEL_PALETTE;
		end
	end

	// nametable fold: 4 KB window, four 1 KB tables; in four-screen mode bit 11 picks the extra RAM
	always_comb begin
		case (mirror_q)
			vuri_pkg::MIR_HORIZ: begin
				name_addr = {1'b0, vptr_q[11], vptr_q[9:0]};
			end
			vuri_pkg::MIR_VERT: begin
				name_addr = {1'b0, vptr_q[10], vptr_q[9:0]};
			end
			default: begin
				name_addr = vptr_q[11:0];
			end
		endcase
	end

	// palette mirrors: sprite backdrop entries fold onto the background ones
	assign pal_addr = {vptr_q[4] && (vptr_q[1:0] == 2'b00) ? 1'b0 : vptr_q[4], vptr_q[3:0]};

	logic vid_acc;
	logic vid_wr;
	logic vid_rd;
	assign vid_acc = accept && (reg_idx == vuri_pkg::REG_VID_DAT);
	assign vid_wr  = vid_acc && is_write;
	assign vid_rd  = vid_acc && is_read;

	logic spr_wr;
	logic spr_rd;
	assign spr_wr = accept && is_write && (reg_idx == vuri_pkg::REG_SPR_DAT);
	assign spr_rd = accept && is_read && (reg_idx == vuri_pkg::REG_SPR_DAT);

	logic [15:0] vptr_step;
	assign vptr_step = {2'b00, 14'(vptr_q[13:0] + (ctrl_inc32_q ? 14'd32 : 14'd1))};

	// ---------------- stores ----------------
	logic [7:0] pat_rdata;
	logic [7:0] name_rdata;
	logic [7:0] pal_rdata;
	logic [7:0] spr_rdata;
	logic [7:0] ram_wdata;

	assign ram_wdata = clear_q ? 8'h00 : req.write_data;

	vuri_ram #(.WIDTH(8), .DEPTH(vuri_pkg::PATTERN_DEPTH)) u_pattern_ram (
		.clk   (clk),
		.we    (clear_q || (vid_wr && vsel == vuri_pkg::VSEL_PATTERN)),
		.re    (vid_rd && vsel == vuri_pkg::VSEL_PATTERN),
		.addr  (clear_q ? clear_cnt_q : vptr_q[PAT_AW-1:0]),
		.wdata (ram_wdata),
		.rdata (pat_rdata)
	);

	vuri_ram #(.WIDTH(8), .DEPTH(vuri_pkg::NAME_DEPTH)) u_name_ram (
		.clk   (clk),
		.we    (clear_q || (vid_wr && vsel == vuri_pkg::VSEL_NAME)),
		.re    (vid_rd && vsel == vuri_pkg::VSEL_NAME),
		.addr  (clear_q ? clear_cnt_q[NAME_AW-1:0] : name_addr),
		.wdata (ram_wdata),
		.rdata (name_rdata)
	);

	vuri_ram #(.WIDTH(8), .DEPTH(vuri_pkg::PAL_DEPTH)) u_palette_ram (
		.clk   (clk),
		.we    (clear_q || (vid_wr && vsel == vuri_pkg::VSEL_PALETTE)),
		.re    (vid_rd && vsel == vuri_pkg::VSEL_PALETTE),
		.addr  (clear_q ? clear_cnt_q[PAL_AW-1:0] : pal_addr),
		.wdata (ram_wdata),
		.rdata (pal_rdata)
	);

	vuri_ram #(.WIDTH(8), .DEPTH(vuri_pkg::SPRITE_DEPTH)) u_sprite_ram (
		.clk   (clk),
		.we    (clear_q || spr_wr),
		.re    (spr_rd),
		.addr  (clear_q ? clear_cnt_q[SPR_AW-1:0] : spr_ptr_q),
		.wdata (ram_wdata),
		.rdata (spr_rdata)
	);

	// ---------------- dot/line timing ----------------
	logic [8:0] dot_inc;
	logic [8:0] dot_nxt;
	logic [8:0] line_nxt;
	logic       at_flag_dot;
	logic       vbl_set;
	logic       vbl_clr;

	assign dot_inc = dot_q + 9'd1;
	always_comb begin
		if (dot_inc >= vuri_pkg::DOTS_PER_LINE) begin
			dot_nxt  = '0;
			line_nxt = (line_q + 9'd1 >= vuri_pkg::LINES_PER_FRAME) ? '0 : line_q + 9'd1;
		end else begin
			dot_nxt  = dot_inc;
			line_nxt = line_q;
		end
	end
	assign at_flag_dot = (dot_nxt == vuri_pkg::FLAG_DOT);
	assign vbl_set     = at_flag_dot && (line_nxt == vuri_pkg::VBLANK_LINE);
	assign vbl_clr     = at_flag_dot && (line_nxt == vuri_pkg::PRERENDER_LINE);

	// vblank after this request, and the interrupt pulse
	logic vblank_nxt;
	logic nmi_nxt;
	always_comb begin
		vblank_nxt = vblank_q;
		nmi_nxt    = 1'b0;
		if (is_tick) begin
			if (vbl_set) begin
				vblank_nxt = 1'b1;
				nmi_nxt    = ctrl_nmi_q;
			end
			if (vbl_clr) begin
				vblank_nxt = 1'b0;
			end
		end else if (is_read && reg_idx == vuri_pkg::REG_STATUS) begin
			vblank_nxt = 1'b0;
		end
	end

	// ---------------- register updates (mirroring on cfg_wr_en) ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= vuri_pkg::MIR_HORIZ;
		end else if (cfg_wr_en) begin
			mirror_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q         <= '0;
			line_q        <= '0;
			vblank_q      <= 1'b0;
			ctrl_nmi_q    <= 1'b0;
			ctrl_inc32_q  <= 1'b0;
			spr_ptr_q     <= '0;
			addr_toggle_q <= 1'b0;
			vptr_q        <= '0;
		end else if (accept) begin
			vblank_q <= vblank_nxt;
			case (req.cmd)
				vuri_pkg::CMD_TICK: begin
					dot_q  <= dot_nxt;
					line_q <= line_nxt;
				end
				vuri_pkg::CMD_READ: begin
					if (reg_idx == vuri_pkg::REG_STATUS) begin
						addr_toggle_q <= 1'b0;
					end
					if (reg_idx == vuri_pkg::REG_VID_DAT) begin
						vptr_q <= vptr_step;
					end
				end
				vuri_pkg::CMD_WRITE: begin
					case (reg_idx)
						vuri_pkg::REG_CTRL: begin
							ctrl_nmi_q   <= req.write_data[7];
							ctrl_inc32_q <= req.write_data[2];
						end
						vuri_pkg::REG_SPR_ADR: begin
							spr_ptr_q <= req.write_data;
						end
						vuri_pkg::REG_SPR_DAT: begin
							spr_ptr_q <= spr_ptr_q + 8'd1;
						end
						vuri_pkg::REG_VID_ADR: begin
							// high byte first (unmasked), low byte second (masks to 14 bits)
							if (!addr_toggle_q) begin
								vptr_q <= {req.write_data, vptr_q[7:0]};
							end else begin
								vptr_q <= {2'b00, vptr_q[13:8], req.write_data};
							end
							addr_toggle_q <= !addr_toggle_q;
						end
						vuri_pkg::REG_VID_DAT: begin
							vptr_q <= vptr_step;
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- stage 1: RAM read data returns ----------------
	logic [1:0] src_s1;
	logic [1:0] vsel_s1;
	logic       nmi_s1;
	logic       vblank_s1;
	logic [1:0] rd_src;

	always_comb begin
		rd_src = vuri_pkg::RD_ZERO;
		if (is_read) begin
			case (reg_idx)
				vuri_pkg::REG_STATUS:  rd_src = vuri_pkg::RD_STATUS;
				vuri_pkg::REG_SPR_DAT: rd_src = vuri_pkg::RD_SPRITE;
				vuri_pkg::REG_VID_DAT: rd_src = vuri_pkg::RD_VIDEO;
				default:               rd_src = vuri_pkg::RD_ZERO;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// status byte read: vblank sampled before the read clears it
	logic status_s1;
	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1    <= rd_src;
			vsel_s1   <= vsel;
			status_s1 <= vblank_q;
			nmi_s1    <= nmi_nxt;
			vblank_s1 <= vblank_nxt;
		end
	end

	logic [7:0] vid_byte;
	logic [7:0] rd_val;

	always_comb begin
		case (vsel_s1)
			vuri_pkg::VSEL_PATTERN: vid_byte = pat_rdata;
			vuri_pkg::VSEL_NAME:    vid_byte = name_rdata;
			vuri_pkg::VSEL_PALETTE: vid_byte = pal_rdata;
			default:                vid_byte = 8'h00;
		endcase
	end

	always_comb begin
		case (src_s1)
			vuri_pkg::RD_STATUS: rd_val = {status_s1, 7'b0};
			vuri_pkg::RD_SPRITE: rd_val = spr_rdata;
			vuri_pkg::RD_VIDEO: begin
				rd_val = (vsel_s1 == vuri_pkg::VSEL_PALETTE) ? vid_byte : rbuf_q;
			end
			default:             rd_val = 8'h00;
		endcase
	end

	// delayed read buffer follows the data reads in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbuf_q <= '0;
		end else if (s1_advance && src_s1 == vuri_pkg::RD_VIDEO) begin
			rbuf_q <= vid_byte;
		end
	end

	// ---------------- response register ----------------
	vuri_pkg::rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			rsp_q.read_data  <= rd_val;
			rsp_q.nmi_raise  <= nmi_s1;
			rsp_q.vblank_now <= vblank_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------- assertions ----------------
	`VURI_ASSERT_NOW(a_no_req_in_clear, clear_q, !req_ready, "request taken during clear pass")
	`VURI_ASSERT_NEXT(a_accept_fills_s1, accept, valid_s1, "transfer lost before stage 1")
	`VURI_ASSERT_NOW(a_nmi_in_vblank, rsp_valid && rsp.nmi_raise, rsp.vblank_now, "nmi without vblank")
	`VURI_ASSERT_NEXT(a_vptr_wrapped, vid_rd || vid_wr, vptr_q[15:14] == 2'b00, "pointer not wrapped")

endmodule

[src/vuri_ram.sv]
// ---------------------------------------------------------------------------
// vuri_ram
// Generic single-port synchronous RAM, registered read.
// ---------------------------------------------------------------------------
module vuri_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
